@@ rtl/lct_pkg.sv @@
package lct_pkg;

   // Defaults for the top-level parameters.
   localparam int unsigned SLOTS_DEF            = 16;
   localparam int unsigned KEY_HEX_DIGITS_DEF   = 16;
   localparam int unsigned MAX_SECRET_BYTES_DEF = 8;

   // Fixed field widths of the request and response items.
   localparam int unsigned CMD_W    = 2;
   localparam int unsigned KEY_W    = 64;
   localparam int unsigned WORD_W   = 64;
   localparam int unsigned LEN_W    = 4;
   localparam int unsigned STATUS_W = 2;
   localparam int unsigned USED_W   = 4;
   localparam int unsigned STAMP_W  = 32;

   // Command codes.
   localparam logic [CMD_W-1:0] CMD_LOOKUP = 2'd0;
   localparam logic [CMD_W-1:0] CMD_SAVE   = 2'd1;
   localparam logic [CMD_W-1:0] CMD_FORGET = 2'd2;

   // Status codes.
   localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
   localparam logic [STATUS_W-1:0] ST_INVALID   = 2'd1;
   localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd2;

   // Write controls from the sequencer to the slot store.
   typedef struct packed {
      logic slot_we;    // write key, secret and length; mark the slot valid
      logic stamp_we;   // write the use stamp
      logic valid_clr;  // mark the slot empty
   } wr_ctl_type;

   // Status flags of the scan unit.
   typedef struct packed {
      logic hit;        // a valid slot holds the key
      logic empty;      // at least one empty slot was seen
   } scan_flags_type;

endpackage

@@ rtl/lct_ifs.sv @@
interface lct_req_if;
   import lct_pkg::*;

   logic                valid;
   logic                ready;
   logic [CMD_W-1:0]    command;
   logic [KEY_W-1:0]    key_digits;
   logic [WORD_W-1:0]   secret_word;
   logic [LEN_W-1:0]    secret_length;

   modport source (output valid, command, key_digits, secret_word, secret_length,
                   input ready);
   modport sink   (input valid, command, key_digits, secret_word, secret_length,
                   output ready);
endinterface

interface lct_rsp_if;
   import lct_pkg::*;

   logic                valid;
   logic                ready;
   logic [STATUS_W-1:0] status;
   logic                found;
   logic [WORD_W-1:0]   secret_out;
   logic [LEN_W-1:0]    secret_out_length;
   logic [USED_W-1:0]   slot_used;

   modport source (output valid, status, found, secret_out, secret_out_length, slot_used,
                   input ready);
   modport sink   (input valid, status, found, secret_out, secret_out_length, slot_used,
                   output ready);
endinterface

@@ rtl/lru_credential_table.sv @@
// Channel  | Direction | Handshake          | Item
// ---------+-----------+--------------------+-----------------------------------------------
// req_chan | in        | valid/ready (sink) | command, key_digits, secret_word, secret_length
// rsp_chan | out       | valid/ready (src)  | status, found, secret_out, secret_out_length,
//          |           |                    | slot_used
//
// Save, forget and a lookup pass from acceptance through the scan, a drain state and a
// decide state before the result is loaded for the response; a lookup that finds its key
// adds a fetch state. The scan reads one slot per cycle through the single read port of the
// slot memory. A save that wraps the use counter adds a restamping pass over every slot. A
// rejected command skips the scan and goes straight to the finish state. Reset clears the
// valid marks directly; there is no clearing pass. The block takes one item at a time and
// waits in its last state while an earlier response is not taken.
module lru_credential_table #(
   parameter int unsigned SLOTS            = lct_pkg::SLOTS_DEF,
   parameter int unsigned KEY_HEX_DIGITS   = lct_pkg::KEY_HEX_DIGITS_DEF,
   parameter int unsigned MAX_SECRET_BYTES = lct_pkg::MAX_SECRET_BYTES_DEF
) (
   input  logic        clock,
   input  logic        reset,
   lct_req_if.sink     req_chan,
   lct_rsp_if.source   rsp_chan
);
   import lct_pkg::*;

   localparam int unsigned IW       = $clog2(SLOTS);
   localparam int unsigned KEY_BITS = 4 * KEY_HEX_DIGITS;
   localparam int unsigned SEC_BITS = 8 * MAX_SECRET_BYTES;

   typedef enum logic [2:0] {
      ST_IDLE,    // waiting for an item
      ST_SCAN,    // issuing slot reads, one per cycle
      ST_DRAIN,   // last slot read is compared
      ST_DECIDE,  // act on the scan result
      ST_FETCH,   // matched slot data is back for a lookup
      ST_WRAP,    // restamping every slot after the use counter wrapped
      ST_FINISH   // hand the result to the output register
   } state_type;

   // Sequencer state and the captured item.
   state_type            state_ff, state_in;
   logic [CMD_W-1:0]     cmd_ff, cmd_in;
   logic [KEY_BITS-1:0]  key_ff, key_in;
   logic [SEC_BITS-1:0]  sec_ff, sec_in;
   logic [LEN_W-1:0]     len_ff, len_in;
   logic [IW-1:0]        addr_ff, addr_in;      // scan and restamp pointer
   logic                 live_ff, live_in;      // read data belongs to the scan
   logic [IW-1:0]        live_idx_ff, live_idx_in;
   logic [STAMP_W-1:0]   use_cnt_ff, use_cnt_in;

   // Result under construction.
   logic [STATUS_W-1:0]  res_status_ff, res_status_in;
   logic                 res_found_ff, res_found_in;
   logic [WORD_W-1:0]    res_sec_ff, res_sec_in;
   logic [LEN_W-1:0]     res_len_ff, res_len_in;
   logic [USED_W-1:0]    res_used_ff, res_used_in;

   // Output register.
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [STATUS_W-1:0]  out_status_ff, out_status_in;
   logic                 out_found_ff, out_found_in;
   logic [WORD_W-1:0]    out_sec_ff, out_sec_in;
   logic [LEN_W-1:0]     out_len_ff, out_len_in;
   logic [USED_W-1:0]    out_used_ff, out_used_in;

   // Store and scan connections.
   logic [IW-1:0]        rd_addr;
   logic                 rd_valid;
   logic [KEY_BITS-1:0]  rd_key;
   logic [SEC_BITS-1:0]  rd_secret;
   logic [LEN_W-1:0]     rd_length;
   logic [STAMP_W-1:0]   rd_stamp;
   wr_ctl_type           wr_ctl;
   logic [IW-1:0]        wr_addr;
   logic [STAMP_W-1:0]   wr_stamp;
   scan_flags_type       scan_flags;
   logic                 scan_clear;
   logic [IW-1:0]        hit_idx;
   logic [IW-1:0]        empty_idx;
   logic [IW-1:0]        best_idx;

   logic                 accept;
   logic                 len_ok;
   logic [SEC_BITS-1:0]  sec_mask;
   logic [IW-1:0]        save_idx;
   logic [STAMP_W-1:0]   cnt_next;
   logic                 out_free;

   // The reported slot number keeps only the low bits of the index.
   function automatic logic [USED_W-1:0] slot_tag(input logic [IW-1:0] idx);
      logic [IW+USED_W-1:0] wide;
      wide = (IW+USED_W)'(idx);
      return wide[USED_W-1:0];
   endfunction

   assign accept   = req_chan.valid && req_chan.ready;
   assign out_free = !rsp_valid_ff || rsp_chan.ready;
   assign len_ok   = (req_chan.secret_length != '0) &&
                     (req_chan.secret_length <= LEN_W'(MAX_SECRET_BYTES));

   // Bytes beyond the password length are dropped before storing.
   always_comb begin
      for (int b = 0; b < MAX_SECRET_BYTES; b++) begin
         sec_mask[b*8 +: 8] = (LEN_W'(b) < req_chan.secret_length) ? 8'hFF : 8'h00;
      end
   end

   // A save reuses the matching slot, else the first empty one, else the oldest.
   assign save_idx = scan_flags.hit   ? hit_idx :
                     scan_flags.empty ? empty_idx : best_idx;
   assign cnt_next = use_cnt_ff + STAMP_W'(1);

   // The read port walks the slots during the scan and then fetches the match.
   assign rd_addr    = (state_ff == ST_SCAN) ? addr_ff : hit_idx;
   assign scan_clear = accept;

   always_comb begin
      state_in      = state_ff;
      cmd_in        = cmd_ff;
      key_in        = key_ff;
      sec_in        = sec_ff;
      len_in        = len_ff;
      addr_in       = addr_ff;
      live_in       = (state_ff == ST_SCAN);
      live_idx_in   = addr_ff;
      use_cnt_in    = use_cnt_ff;
      res_status_in = res_status_ff;
      res_found_in  = res_found_ff;
      res_sec_in    = res_sec_ff;
      res_len_in    = res_len_ff;
      res_used_in   = res_used_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_chan.ready;
      out_status_in = out_status_ff;
      out_found_in  = out_found_ff;
      out_sec_in    = out_sec_ff;
      out_len_in    = out_len_ff;
      out_used_in   = out_used_ff;
      wr_ctl        = '0;
      wr_addr       = save_idx;
      wr_stamp      = use_cnt_ff;

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               cmd_in        = req_chan.command;
               key_in        = req_chan.key_digits[KEY_BITS-1:0];
               sec_in        = req_chan.secret_word[SEC_BITS-1:0] & sec_mask;
               len_in        = req_chan.secret_length;
               addr_in       = '0;
               res_status_in = ST_INVALID;
               res_found_in  = 1'b0;
               res_sec_in    = '0;
               res_len_in    = '0;
               res_used_in   = '0;
               // Unused commands and bad lengths are rejected without a scan.
               if ((req_chan.command == CMD_LOOKUP) || (req_chan.command == CMD_FORGET) ||
                   ((req_chan.command == CMD_SAVE) && len_ok)) begin
                  state_in = ST_SCAN;
               end else begin
                  state_in = ST_FINISH;
               end
            end
         end
         ST_SCAN: begin
            if (addr_ff == IW'(SLOTS - 1)) begin
               state_in = ST_DRAIN;
            end else begin
               addr_in = addr_ff + IW'(1);
            end
         end
         ST_DRAIN: begin
            state_in = ST_DECIDE;
         end
         ST_DECIDE: begin
            state_in = ST_FINISH;
            case (cmd_ff)
               CMD_LOOKUP: begin
                  if (scan_flags.hit) begin
                     state_in = ST_FETCH;
                  end else begin
                     res_status_in = ST_NOT_FOUND;
                  end
               end
               CMD_SAVE: begin
                  wr_ctl.slot_we  = 1'b1;
                  wr_ctl.stamp_we = 1'b1;
                  wr_addr         = save_idx;
                  wr_stamp        = use_cnt_ff;
                  res_status_in   = ST_OK;
                  res_used_in     = slot_tag(save_idx);
                  if (cnt_next == '0) begin
                     // The counter wrapped: restamp all slots by index, then
                     // restart just past the capacity.
                     use_cnt_in = STAMP_W'(SLOTS) + STAMP_W'(1);
                     addr_in    = '0;
                     state_in   = ST_WRAP;
                  end else begin
                     use_cnt_in = cnt_next;
                  end
               end
               CMD_FORGET: begin
                  if (scan_flags.hit) begin
                     wr_ctl.valid_clr = 1'b1;
                     wr_addr          = hit_idx;
                     res_status_in    = ST_OK;
                     res_found_in     = 1'b1;
                     res_used_in      = slot_tag(hit_idx);
                  end else begin
                     res_status_in = ST_NOT_FOUND;
                  end
               end
               default: begin
                  res_status_in = ST_INVALID;
               end
            endcase
         end
         ST_FETCH: begin
            res_status_in = ST_OK;
            res_found_in  = 1'b1;
            res_sec_in    = WORD_W'(rd_secret);
            res_len_in    = rd_length;
            res_used_in   = slot_tag(hit_idx);
            state_in      = ST_FINISH;
         end
         ST_WRAP: begin
            // Empty slots get a stamp too; it is never read before a save rewrites it.
            wr_ctl.stamp_we = 1'b1;
            wr_addr         = addr_ff;
            wr_stamp        = STAMP_W'(addr_ff) + STAMP_W'(1);
            if (addr_ff == IW'(SLOTS - 1)) begin
               state_in = ST_FINISH;
            end else begin
               addr_in = addr_ff + IW'(1);
            end
         end
         ST_FINISH: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               out_status_in = res_status_ff;
               out_found_in  = res_found_ff;
               out_sec_in    = res_sec_ff;
               out_len_in    = res_len_ff;
               out_used_in   = res_used_ff;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         live_ff      <= 1'b0;
         use_cnt_ff   <= STAMP_W'(1);
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         live_ff      <= live_in;
         use_cnt_ff   <= use_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      cmd_ff        <= cmd_in;
      key_ff        <= key_in;
      sec_ff        <= sec_in;
      len_ff        <= len_in;
      addr_ff       <= addr_in;
      live_idx_ff   <= live_idx_in;
      res_status_ff <= res_status_in;
      res_found_ff  <= res_found_in;
      res_sec_ff    <= res_sec_in;
      res_len_ff    <= res_len_in;
      res_used_ff   <= res_used_in;
      out_status_ff <= out_status_in;
      out_found_ff  <= out_found_in;
      out_sec_ff    <= out_sec_in;
      out_len_ff    <= out_len_in;
      out_used_ff   <= out_used_in;
   end

   lct_store #(
      .SLOTS    (SLOTS),
      .KEY_BITS (KEY_BITS),
      .SEC_BITS (SEC_BITS)
   ) u_store (
      .clock     (clock),
      .reset     (reset),
      .rd_addr   (rd_addr),
      .rd_valid  (rd_valid),
      .rd_key    (rd_key),
      .rd_secret (rd_secret),
      .rd_length (rd_length),
      .rd_stamp  (rd_stamp),
      .wr_ctl    (wr_ctl),
      .wr_addr   (wr_addr),
      .wr_key    (key_ff),
      .wr_secret (sec_ff),
      .wr_length (len_ff),
      .wr_stamp  (wr_stamp)
   );

   lct_scan #(
      .SLOTS    (SLOTS),
      .KEY_BITS (KEY_BITS)
   ) u_scan (
      .clock      (clock),
      .reset      (reset),
      .clear      (scan_clear),
      .check      (live_ff),
      .idx        (live_idx_ff),
      .slot_valid (rd_valid),
      .slot_key   (rd_key),
      .slot_stamp (rd_stamp),
      .key        (key_ff),
      .flags      (scan_flags),
      .hit_idx    (hit_idx),
      .empty_idx  (empty_idx),
      .best_idx   (best_idx)
   );

   assign req_chan.ready             = (state_ff == ST_IDLE);
   assign rsp_chan.valid             = rsp_valid_ff;
   assign rsp_chan.status            = out_status_ff;
   assign rsp_chan.found             = out_found_ff;
   assign rsp_chan.secret_out        = out_sec_ff;
   assign rsp_chan.secret_out_length = out_len_ff;
   assign rsp_chan.slot_used         = out_used_ff;

`ifndef ASSERT_OFF
   // The use counter never holds zero; a wrap always restarts it past the capacity.
   a_cnt_nonzero: assert property (@(posedge clock) disable iff (reset)
      use_cnt_ff != '0)
      else $error("use counter is zero");

   // Leaving the restamp sweep, the counter sits just past the capacity.
   a_wrap_restart: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_WRAP) && (addr_ff == IW'(SLOTS - 1)) |=>
         use_cnt_ff == STAMP_W'(SLOTS) + STAMP_W'(1))
      else $error("use counter not restarted after wrap");

   // A matched result always reports success.
   a_found_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && out_found_ff |-> out_status_ff == ST_OK)
      else $error("found set on a failed command");

   // Only a successful lookup carries password data.
   a_secret_only_lookup: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !out_found_ff |-> (out_sec_ff == '0) && (out_len_ff == '0))
      else $error("password data on a result without a match");

   // No slot write happens while an item is being scanned.
   a_no_write_in_scan: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN) || (state_ff == ST_DRAIN) |->
         !wr_ctl.slot_we && !wr_ctl.stamp_we && !wr_ctl.valid_clr)
      else $error("slot store written during scan");
`endif

endmodule

@@ rtl/lct_store.sv @@
module lct_store #(
   parameter int unsigned SLOTS    = lct_pkg::SLOTS_DEF,
   parameter int unsigned KEY_BITS = 4 * lct_pkg::KEY_HEX_DIGITS_DEF,
   parameter int unsigned SEC_BITS = 8 * lct_pkg::MAX_SECRET_BYTES_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic [$clog2(SLOTS)-1:0]      rd_addr,
   output logic                          rd_valid,
   output logic [KEY_BITS-1:0]           rd_key,
   output logic [SEC_BITS-1:0]           rd_secret,
   output logic [lct_pkg::LEN_W-1:0]     rd_length,
   output logic [lct_pkg::STAMP_W-1:0]   rd_stamp,
   input  lct_pkg::wr_ctl_type           wr_ctl,
   input  logic [$clog2(SLOTS)-1:0]      wr_addr,
   input  logic [KEY_BITS-1:0]           wr_key,
   input  logic [SEC_BITS-1:0]           wr_secret,
   input  logic [lct_pkg::LEN_W-1:0]     wr_length,
   input  logic [lct_pkg::STAMP_W-1:0]   wr_stamp
);
   import lct_pkg::*;

   // Slot contents live in memories; only the valid marks are flip-flops,
   // so an empty slot is never trusted for its data.
   logic [KEY_BITS-1:0] key_mem   [SLOTS];
   logic [SEC_BITS-1:0] sec_mem   [SLOTS];
   logic [LEN_W-1:0]    len_mem   [SLOTS];
   logic [STAMP_W-1:0]  stamp_mem [SLOTS];
   logic [SLOTS-1:0]    valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (wr_ctl.slot_we) begin
         valid_ff[wr_addr] <= 1'b1;
      end else if (wr_ctl.valid_clr) begin
         valid_ff[wr_addr] <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_ctl.slot_we) begin
         key_mem[wr_addr] <= wr_key;
         sec_mem[wr_addr] <= wr_secret;
         len_mem[wr_addr] <= wr_length;
      end
      if (wr_ctl.stamp_we) begin
         stamp_mem[wr_addr] <= wr_stamp;
      end
   end

   always_ff @(posedge clock) begin
      rd_valid  <= valid_ff[rd_addr];
      rd_key    <= key_mem[rd_addr];
      rd_secret <= sec_mem[rd_addr];
      rd_length <= len_mem[rd_addr];
      rd_stamp  <= stamp_mem[rd_addr];
   end

endmodule

@@ rtl/lct_scan.sv @@
module lct_scan #(
   parameter int unsigned SLOTS    = lct_pkg::SLOTS_DEF,
   parameter int unsigned KEY_BITS = 4 * lct_pkg::KEY_HEX_DIGITS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          clear,
   input  logic                          check,
   input  logic [$clog2(SLOTS)-1:0]      idx,
   input  logic                          slot_valid,
   input  logic [KEY_BITS-1:0]           slot_key,
   input  logic [lct_pkg::STAMP_W-1:0]   slot_stamp,
   input  logic [KEY_BITS-1:0]           key,
   output lct_pkg::scan_flags_type       flags,
   output logic [$clog2(SLOTS)-1:0]      hit_idx,
   output logic [$clog2(SLOTS)-1:0]      empty_idx,
   output logic [$clog2(SLOTS)-1:0]      best_idx
);
   import lct_pkg::*;

   localparam int unsigned IW = $clog2(SLOTS);

   scan_flags_type     flags_ff, flags_in;
   logic               have_best_ff, have_best_in;
   logic [IW-1:0]      hit_idx_ff, hit_idx_in;
   logic [IW-1:0]      empty_idx_ff, empty_idx_in;
   logic [IW-1:0]      best_idx_ff, best_idx_in;
   logic [STAMP_W-1:0] best_stamp_ff, best_stamp_in;

   // One slot per check: key compare for the first match, first empty slot,
   // and a running minimum of the stamps (strict less keeps the lowest index).
   always_comb begin
      flags_in      = flags_ff;
      have_best_in  = have_best_ff;
      hit_idx_in    = hit_idx_ff;
      empty_idx_in  = empty_idx_ff;
      best_idx_in   = best_idx_ff;
      best_stamp_in = best_stamp_ff;
      if (clear) begin
         flags_in     = '0;
         have_best_in = 1'b0;
      end else if (check) begin
         if (slot_valid && (slot_key == key) && !flags_ff.hit) begin
            flags_in.hit = 1'b1;
            hit_idx_in   = idx;
         end
         if (!slot_valid && !flags_ff.empty) begin
            flags_in.empty = 1'b1;
            empty_idx_in   = idx;
         end
         if (slot_valid && (!have_best_ff || (slot_stamp < best_stamp_ff))) begin
            have_best_in  = 1'b1;
            best_idx_in   = idx;
            best_stamp_in = slot_stamp;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         flags_ff     <= '0;
         have_best_ff <= 1'b0;
      end else begin
         flags_ff     <= flags_in;
         have_best_ff <= have_best_in;
      end
      hit_idx_ff    <= hit_idx_in;
      empty_idx_ff  <= empty_idx_in;
      best_idx_ff   <= best_idx_in;
      best_stamp_ff <= best_stamp_in;
   end

   assign flags     = flags_ff;
   assign hit_idx   = hit_idx_ff;
   assign empty_idx = empty_idx_ff;
   assign best_idx  = best_idx_ff;

endmodule

@@ sim/lru_credential_table_tb.sv @@
`timescale 1ns / 1ps

// Self-checking bench for the credential table. A tracker object mirrors the
// slot store and the use counter, predicts one reply for every accepted
// request item and checks each reply item against the oldest prediction.
module lru_credential_table_tb;
   import lct_pkg::*;

   localparam int unsigned SLOTS            = SLOTS_DEF;
   localparam int unsigned KEY_HEX_DIGITS   = KEY_HEX_DIGITS_DEF;
   localparam int unsigned MAX_SECRET_BYTES = MAX_SECRET_BYTES_DEF;

   // The one command code that the block does not define.
   localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

   localparam int unsigned RANDOM_ITEMS = 1100;
   // Longest run of cycles without any accepted item before the run is ended.
   // It has to cover a single command, a counter wrap and a stall on the receiver side.
   localparam int unsigned STALL_LIMIT  = 2000;

   // Mask for the key digits that count.
   localparam logic [KEY_W-1:0] KEY_MASK = (KEY_HEX_DIGITS >= 16) ? {KEY_W{1'b1}} :
                                           ((64'd1 << (4 * KEY_HEX_DIGITS)) - 64'd1);

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic                found;
      logic [WORD_W-1:0]   secret;
      logic [LEN_W-1:0]    length;
      logic [USED_W-1:0]   slot;
   } reply_type;

   // Mirror of the credential table plus the queue of replies still owed.
   class credential_tracker;
      bit                 slot_full   [SLOTS];
      logic [KEY_W-1:0]   slot_key    [SLOTS];
      logic [WORD_W-1:0]  slot_secret [SLOTS];
      logic [LEN_W-1:0]   slot_length [SLOTS];
      bit   [STAMP_W-1:0] slot_stamp  [SLOTS];
      bit   [STAMP_W-1:0] use_count;
      reply_type          owed_replies[$];
      int unsigned        mismatches;

      function new();
         for (int i = 0; i < SLOTS; i++) begin
            slot_full[i]   = 1'b0;
            slot_key[i]    = '0;
            slot_secret[i] = '0;
            slot_length[i] = '0;
            slot_stamp[i]  = '0;
         end
         use_count  = 1;
         mismatches = 0;
      endfunction

      function int unsigned outstanding();
         return owed_replies.size();
      endfunction

      // Index of the valid slot holding the key, or -1.
      function int match_slot(logic [KEY_W-1:0] key);
         for (int i = 0; i < SLOTS; i++)
            if (slot_full[i] && slot_key[i] == key)
               return i;
         return -1;
      endfunction

      // First empty slot, else the oldest stamp with the lowest index on a tie.
      function int replace_slot();
         int best;
         best = 0;
         for (int i = 0; i < SLOTS; i++) begin
            if (!slot_full[i])
               return i;
            if (slot_stamp[i] < slot_stamp[best])
               best = i;
         end
         return best;
      endfunction

      // Applies one command to the mirror and returns the reply it causes.
      function reply_type predict_reply(logic [CMD_W-1:0] cmd, logic [KEY_W-1:0] key_in,
                                        logic [WORD_W-1:0] word, logic [LEN_W-1:0] len);
         reply_type         r;
         logic [KEY_W-1:0]  key;
         logic [WORD_W-1:0] keep;
         int                idx;
         key  = key_in & KEY_MASK;
         r    = '0;
         r.status = ST_INVALID;
         case (cmd)
            CMD_LOOKUP: begin
               idx = match_slot(key);
               if (idx < 0) begin
                  r.status = ST_NOT_FOUND;
               end else begin
                  r.status = ST_OK;
                  r.found  = 1'b1;
                  r.secret = slot_secret[idx];
                  r.length = slot_length[idx];
                  r.slot   = idx[USED_W-1:0];
               end
            end
            CMD_SAVE: begin
               if (len >= 1 && len <= MAX_SECRET_BYTES) begin
                  idx = match_slot(key);
                  if (idx < 0)
                     idx = replace_slot();
                  keep = (len >= 8) ? {WORD_W{1'b1}} : ((64'd1 << (8 * len)) - 64'd1);
                  slot_full[idx]   = 1'b1;
                  slot_key[idx]    = key;
                  slot_secret[idx] = word & keep;
                  slot_length[idx] = len;
                  slot_stamp[idx]  = use_count;
                  use_count        = use_count + 1;
                  // On a counter wrap the stamps are rebuilt from the slot order.
                  if (use_count == 0) begin
                     for (int i = 0; i < SLOTS; i++)
                        slot_stamp[i] = slot_full[i] ? STAMP_W'(i + 1) : '0;
                     use_count = SLOTS + 1;
                  end
                  r.status = ST_OK;
                  r.slot   = idx[USED_W-1:0];
               end
            end
            CMD_FORGET: begin
               idx = match_slot(key);
               if (idx < 0) begin
                  r.status = ST_NOT_FOUND;
               end else begin
                  slot_full[idx]   = 1'b0;
                  slot_key[idx]    = '0;
                  slot_secret[idx] = '0;
                  slot_length[idx] = '0;
                  slot_stamp[idx]  = '0;
                  r.status = ST_OK;
                  r.found  = 1'b1;
                  r.slot   = idx[USED_W-1:0];
               end
            end
            default: ;
         endcase
         return r;
      endfunction

      function void note_request(logic [CMD_W-1:0] cmd, logic [KEY_W-1:0] key,
                                 logic [WORD_W-1:0] word, logic [LEN_W-1:0] len);
         owed_replies.push_back(predict_reply(cmd, key, word, len));
      endfunction

      function void check_response(reply_type got);
         reply_type want;
         bit        bad;
         if (owed_replies.size() == 0) begin
            if (mismatches < 10)
               $display("%0t: reply with none owed: status %0d found %0d secret %h %s",
                        $realtime, got.status, got.found, got.secret,
                        $sformatf("len %0d slot %0d", got.length, got.slot));
            mismatches++;
            return;
         end
         want = owed_replies.pop_front();
         bad  = (got.status !== want.status) || (got.found !== want.found) ||
                (got.secret !== want.secret) || (got.length !== want.length) ||
                (got.slot !== want.slot);
         if (bad) begin
            if (mismatches < 10) begin
               $display("%0t: reply mismatch", $realtime);
               $display("   expected status %0d found %0d secret %h len %0d slot %0d",
                        want.status, want.found, want.secret, want.length, want.slot);
               $display("   actual   status %0d found %0d secret %h len %0d slot %0d",
                        got.status, got.found, got.secret, got.length, got.slot);
            end
            mismatches++;
         end
      endfunction
   endclass

   logic clock;
   logic reset;

   lct_req_if req_bus();
   lct_rsp_if rsp_bus();

   lru_credential_table DUT (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_bus),
      .rsp_chan (rsp_bus)
   );

   credential_tracker tracker;

   // Keys drawn from a small pool so that saves, lookups and forgets hit the
   // same slots and the table fills up and starts evicting.
   logic [KEY_W-1:0] key_pool[40];

   int unsigned idle_cycles;
   int unsigned rx_mode;
   int unsigned rx_mode_left;
   int unsigned rx_hold_left;

   initial clock = 1'b0;
   always #6 clock = ~clock;

   // Both channels are observed at the rising edge; the tracker sees every
   // accepted item in order on both sides.
   always @(posedge clock) begin
      if (!reset) begin
         if (req_bus.valid && req_bus.ready)
            tracker.note_request(req_bus.command, req_bus.key_digits,
                                 req_bus.secret_word, req_bus.secret_length);
         if (rsp_bus.valid && rsp_bus.ready)
            tracker.check_response('{status: rsp_bus.status, found: rsp_bus.found,
                                     secret: rsp_bus.secret_out,
                                     length: rsp_bus.secret_out_length,
                                     slot:   rsp_bus.slot_used});
      end
   end

   // Watchdog: ends the run if no item moves on either channel for too long.
   always @(posedge clock) begin
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= STALL_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
         end
      end
   end

   // The reply side switches between its own stall patterns: always ready,
   // coin flips, rare ready, and long blocked stretches.
   always @(negedge clock) begin
      if (reset) begin
         rsp_bus.ready <= 1'b0;
         rx_mode_left  = 0;
         rx_hold_left  = 0;
      end else begin
         if (rx_mode_left == 0) begin
            rx_mode      = $urandom_range(0, 3);
            rx_mode_left = $urandom_range(40, 300);
         end
         rx_mode_left--;
         case (rx_mode)
            0: rsp_bus.ready <= 1'b1;
            1: rsp_bus.ready <= 1'($urandom_range(0, 1));
            2: rsp_bus.ready <= ($urandom_range(0, 7) == 0);
            default: begin
               if (rx_hold_left > 0) begin
                  rsp_bus.ready <= 1'b0;
                  rx_hold_left--;
               end else begin
                  rsp_bus.ready <= 1'b1;
                  rx_hold_left = $urandom_range(5, 40);
               end
            end
         endcase
      end
   end

   // Presents one request item and holds it until the table takes it. The
   // valid line stays high into the next item when no gap follows.
   task automatic send_item(input logic [CMD_W-1:0] cmd, input logic [KEY_W-1:0] key,
                            input logic [WORD_W-1:0] word, input logic [LEN_W-1:0] len);
      @(negedge clock);
      req_bus.valid         <= 1'b1;
      req_bus.command       <= cmd;
      req_bus.key_digits    <= key;
      req_bus.secret_word   <= word;
      req_bus.secret_length <= len;
      do
         @(posedge clock);
      while (!req_bus.ready);
   endtask

   task automatic idle_sender(input int unsigned cycles);
      repeat (cycles) begin
         @(negedge clock);
         req_bus.valid <= 1'b0;
      end
   endtask

   // Holds the request side quiet until every owed reply has come back.
   task automatic drain_replies();
      @(negedge clock);
      req_bus.valid <= 1'b0;
      while (tracker.outstanding() != 0)
         @(negedge clock);
   endtask

   // One random command. Most are well-formed saves, lookups and forgets on
   // pooled keys; the rest use fresh keys, bad lengths or the unused code.
   task automatic send_random_item(input int unsigned pool_size);
      int unsigned       pick;
      int unsigned       bad_len;
      logic [CMD_W-1:0]  cmd;
      logic [KEY_W-1:0]  key;
      logic [WORD_W-1:0] word;
      logic [LEN_W-1:0]  len;
      pick = $urandom_range(0, 99);
      if ($urandom_range(0, 9) == 0)
         key = {$urandom, $urandom};
      else
         key = key_pool[$urandom_range(0, pool_size - 1)];
      word = {$urandom, $urandom};
      len  = LEN_W'($urandom_range(0, 15));
      if (pick < 45) begin
         cmd = CMD_SAVE;
         len = LEN_W'($urandom_range(1, MAX_SECRET_BYTES));
      end else if (pick < 75) begin
         cmd = CMD_LOOKUP;
      end else if (pick < 92) begin
         cmd = CMD_FORGET;
      end else if (pick < 96) begin
         cmd = CMD_UNUSED;
      end else begin
         // A save with an empty or overlong password.
         cmd     = CMD_SAVE;
         bad_len = $urandom_range(0, 7);
         len     = (bad_len == 0) ? LEN_W'(0) : LEN_W'(bad_len + 8);
      end
      send_item(cmd, key, word, len);
   endtask

   initial begin
      int unsigned sent;
      int unsigned burst;
      int unsigned pool_size;

      // All request inputs are driven to known values from time zero.
      reset                 <= 1'b1;
      req_bus.valid         <= 1'b0;
      req_bus.command       <= CMD_LOOKUP;
      req_bus.key_digits    <= '0;
      req_bus.secret_word   <= '0;
      req_bus.secret_length <= '0;

      tracker = new();
      for (int i = 0; i < 40; i++)
         key_pool[i] = {$urandom, $urandom};

      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed part. An empty table answers not found to lookup and forget.
      send_item(CMD_LOOKUP, '0, '0, 4'd0);
      send_item(CMD_FORGET, {KEY_W{1'b1}}, '0, 4'd3);
      // Empty and overlong passwords and the unused command are rejected.
      send_item(CMD_SAVE, 64'h1234, {WORD_W{1'b1}}, 4'd0);
      send_item(CMD_SAVE, 64'h1234, {WORD_W{1'b1}}, 4'd9);
      send_item(CMD_SAVE, 64'h1234, {WORD_W{1'b1}}, 4'd15);
      send_item(CMD_UNUSED, {KEY_W{1'b1}}, {WORD_W{1'b1}}, 4'd15);
      // Shortest and longest passwords under the extreme keys.
      send_item(CMD_SAVE, '0, {WORD_W{1'b1}}, 4'd1);
      send_item(CMD_SAVE, {KEY_W{1'b1}}, {WORD_W{1'b1}}, 4'd8);
      send_item(CMD_LOOKUP, '0, {WORD_W{1'b1}}, 4'd15);
      send_item(CMD_LOOKUP, {KEY_W{1'b1}}, '0, 4'd0);
      // A save on a stored key overwrites that slot in place.
      send_item(CMD_SAVE, '0, 64'h0123_4567_89ab_cdef, 4'd4);
      // A forget clears the slot, and the next save takes the freed slot.
      send_item(CMD_FORGET, '0, '0, 4'd0);
      send_item(CMD_LOOKUP, '0, '0, 4'd0);
      send_item(CMD_SAVE, 64'h5, 64'hfedc_ba98_7654_3210, 4'd7);
      // Fill the rest of the table, then force an eviction of the oldest slot.
      for (int i = 0; i < 14; i++)
         send_item(CMD_SAVE, 64'h100 + i, {$urandom, $urandom}, LEN_W'(1 + i % 8));
      send_item(CMD_SAVE, 64'habc, {$urandom, $urandom}, 4'd8);
      send_item(CMD_LOOKUP, {KEY_W{1'b1}}, '0, 4'd0);
      drain_replies();

      // Random part: bursts of items with gaps between them, in phases with a
      // dense key pool, one just above the table size and a sparse one.
      sent      = 0;
      pool_size = 20;
      while (sent < RANDOM_ITEMS) begin
         if (sent % 250 < 2)
            pool_size = (sent / 250 % 3 == 0) ? 6 : ((sent / 250 % 3 == 1) ? 20 : 40);
         burst = $urandom_range(1, 24);
         for (int b = 0; b < burst && sent < RANDOM_ITEMS; b++) begin
            send_random_item(pool_size);
            sent++;
         end
         if ($urandom_range(0, 9) == 0)
            drain_replies();
         else if ($urandom_range(0, 3) != 0)
            idle_sender($urandom_range(1, 30));
      end

      drain_replies();
      repeat (SLOTS * 3) @(posedge clock);

      if (tracker.mismatches == 0 && tracker.outstanding() == 0)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end

endmodule

@@ sim.f @@
rtl/lct_pkg.sv
rtl/lct_ifs.sv
rtl/lct_store.sv
rtl/lct_scan.sv
rtl/lru_credential_table.sv
sim/lru_credential_table_tb.sv
